### hdl/assert_macros.svh
// Assertion macros for the RTL files of the raster sample decoder.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### hdl/prsd_pkg.sv
// Package of the raster sample decoder: types, codes and constants.
// Used by every module of the block; depends on nothing.
package prsd_pkg;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RASTER_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 2'd3;
  localparam int CFG_DATA_W = 16;

  // Raster format codes.
  localparam logic FMT_BITMAP = 1'b0;
  localparam logic FMT_SAMPLE = 1'b1;

  // Reset values of the registers.
  localparam logic        RST_RASTER_FORMAT = FMT_SAMPLE;
  localparam logic [1:0]  RST_CHANNEL_COUNT = 2'd1;
  localparam logic [15:0] RST_MAX_VALUE     = 16'd255;
  localparam logic [12:0] RST_ROW_WIDTH     = 13'd1;

  // Largest row width the register can express.
  localparam int ROW_WIDTH_REG_MAX = 8191;
  localparam int DEF_MAX_ROW_PIXELS = 4096;

  // Sample scaling.
  localparam logic [15:0] FULL_NARROW = 16'd255;
  localparam logic [15:0] FULL_WIDE   = 16'hFFFF;
  localparam logic [15:0] BYTE_MAX    = 16'd255;

  // Bit index of the last bit of a bitmap byte, and the last divider step.
  localparam logic [2:0] BIT_LAST  = 3'd7;
  localparam logic [3:0] STEP_LAST = 4'd15;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_BITMAP = 1'b0,
    KIND_SAMPLE = 1'b1
  } item_kind_t;

  // One classified work item.
  typedef struct packed {
    item_kind_t  kind;
    logic [15:0] data;
  } q_item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_EMIT = 5'b01000,
    S_BITS = 5'b10000
  } back_state_t;

endpackage

### hdl/pnm_raster_sample_decoder_core.sv
// Raster sample decoder for binary netpbm raster bytes.
// The input channel takes one raw byte per beat; the output channel gives
// one normalized sample per beat with a flag on the last sample of a row.
// Bitmap bytes yield up to eight samples (set bit 0, clear bit 255, row
// padding dropped); gray or colour bytes yield one sample, or one sample per
// two bytes when max_value exceeds 255, clamped and scaled to full range.
// A front end takes bytes and joins sample halves into a two-entry queue; a
// back end drains the queue one item at a time.
// A bitmap byte is fetched from the queue and then expanded into its samples;
// a sample passes S_PREP, the 16-step divider and S_EMIT, or goes straight
// to S_EMIT when max_value is zero; the high byte of a two-byte sample is
// absorbed by the front. Each item passes the queue, the back-end sequencer
// and the output register; while out_stall is high on a valid beat that
// register holds and the back end waits, and the front keeps taking bytes
// until the queue fills. Reset (rst_n low, synchronous) loads the register
// defaults, empties the queue and clears the row counter and any pending
// high byte. Registers are written through cfg_we, cfg_index and cfg_wdata;
// the user must do so only while the block idles; the block does not
// enforce it. Depends on prsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pnm_raster_sample_decoder_core #(
  parameter int MAX_ROW_PIXELS = prsd_pkg::DEF_MAX_ROW_PIXELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_raw_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     out_sample_value,
  output logic                            out_last_in_row,
  input  logic                            cfg_we,
  input  logic [prsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic        raster_format_r;
  logic [1:0]  channel_count_r;
  logic [15:0] max_value_r;
  logic [12:0] row_width_r;

  logic                push;
  logic                pop;
  prsd_pkg::q_item_t   push_item;
  prsd_pkg::q_item_t   pop_item;
  prsd_pkg::q_status_t q_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raster_format_r <= prsd_pkg::RST_RASTER_FORMAT;
      channel_count_r <= prsd_pkg::RST_CHANNEL_COUNT;
      max_value_r     <= prsd_pkg::RST_MAX_VALUE;
      row_width_r     <= prsd_pkg::RST_ROW_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        prsd_pkg::REG_RASTER_FORMAT: raster_format_r <= cfg_wdata[0];
        prsd_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[1:0];
        prsd_pkg::REG_MAX_VALUE:     max_value_r     <= cfg_wdata[15:0];
        prsd_pkg::REG_ROW_WIDTH:     row_width_r     <= cfg_wdata[12:0];
        default: begin
        end
      endcase
    end
  end

  // Byte intake and classification.
  prsd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_byte   (in_raw_byte),
    .raster_format (raster_format_r),
    .max_value     (max_value_r),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  // Queue between front and back.
  prsd_fifo #(
    .DEPTH (prsd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // Sample generation.
  prsd_back #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .pop_item         (pop_item),
    .pop              (pop),
    .channel_count    (channel_count_r),
    .max_value        (max_value_r),
    .row_width        (row_width_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_last_in_row  (out_last_in_row)
  );

  // The front never writes a full queue and the back never reads an empty one.
  `ASSERT_NEVER(a_push_full, clk, rst_n, push && q_status.full)
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && q_status.empty)
  // A write without a read leaves something queued in the next cycle.
  `ASSERT_PROP(a_push_fills, clk, rst_n, (push && !pop) |=> !q_status.empty)

endmodule

### hdl/prsd_front.sv
// Front end of the raster sample decoder: accepts raw bytes, joins
// two-byte samples and classifies each item. Depends on prsd_pkg.
module prsd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_raw_byte,
  input  logic                 raster_format,
  input  logic [15:0]          max_value,
  input  prsd_pkg::q_status_t  q_status,
  output logic                 push,
  output prsd_pkg::q_item_t    push_item
);

  logic       await_r, await_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       accept;
  logic       wide;

  // The front waits whenever the queue has no room.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign wide     = max_value > prsd_pkg::BYTE_MAX;

  // Classify the beat and keep a pending high byte.
  always_comb begin
    await_nxt      = await_r;
    hold_nxt       = hold_r;
    push           = 1'b0;
    push_item.kind = prsd_pkg::KIND_BITMAP;
    push_item.data = {8'd0, in_raw_byte};
    if (accept) begin
      if (raster_format == prsd_pkg::FMT_BITMAP) begin
        push      = 1'b1;
        await_nxt = 1'b0;
        hold_nxt  = 8'd0;
      end else if (wide && !await_r) begin
        await_nxt = 1'b1;
        hold_nxt  = in_raw_byte;
      end else begin
        push           = 1'b1;
        push_item.kind = prsd_pkg::KIND_SAMPLE;
        push_item.data = wide ? {hold_r, in_raw_byte} : {8'd0, in_raw_byte};
        await_nxt      = 1'b0;
        hold_nxt       = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b0;
      hold_r  <= 8'd0;
    end else begin
      await_r <= await_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

### hdl/prsd_fifo.sv
// Short register queue between the front and the back of the decoder.
// Depends on prsd_pkg for the item and status types.
module prsd_fifo #(
  parameter int DEPTH = prsd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  prsd_pkg::q_item_t    push_item,
  input  logic                 pop,
  output prsd_pkg::q_item_t    pop_item,
  output prsd_pkg::q_status_t  status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  prsd_pkg::q_item_t  slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign status.full  = count_r == CNT_W'(DEPTH);
  assign status.empty = count_r == '0;
  assign pop_item     = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/prsd_back.sv
// Back end of the raster sample decoder: expands bitmap bytes, scales
// samples with a bit-serial divider and tracks rows. Depends on prsd_pkg.
module prsd_back #(
  parameter int MAX_ROW_PIXELS = prsd_pkg::DEF_MAX_ROW_PIXELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  prsd_pkg::q_status_t  q_status,
  input  prsd_pkg::q_item_t    pop_item,
  output logic                 pop,
  input  logic [1:0]           channel_count,
  input  logic [15:0]          max_value,
  input  logic [12:0]          row_width,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_sample_value,
  output logic                 out_last_in_row
);

  localparam int RowPixMax = (MAX_ROW_PIXELS < prsd_pkg::ROW_WIDTH_REG_MAX) ?
                             MAX_ROW_PIXELS : prsd_pkg::ROW_WIDTH_REG_MAX;
  localparam int PIX_W = $clog2(RowPixMax + 1);
  localparam int CNT_W = $clog2(RowPixMax * 3 + 1);

  prsd_pkg::back_state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [15:0]      val_r, val_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [15:0]      quo_r, quo_nxt;
  logic [3:0]       step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_sample_r, out_sample_nxt;
  logic             out_last_r, out_last_nxt;

  logic [PIX_W-1:0] pix;
  logic [1:0]       chans;
  logic [PIX_W+1:0] pix_chans;
  logic [CNT_W-1:0] row_len;
  logic [CNT_W:0]   cnt_inc;
  logic             row_end;
  logic             wide;
  logic [15:0]      full;
  logic [31:0]      scaled;
  logic [16:0]      trial;
  logic             trial_ge;
  logic             out_free;

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_r;
  assign out_last_in_row  = out_last_r;
  assign out_free         = !out_valid_r || !out_stall;

  // Row length from the registers; zero width counts as one pixel.
  always_comb begin
    if (row_width == 13'd0) begin
      pix = PIX_W'(1);
    end else if ({19'd0, row_width} > 32'(MAX_ROW_PIXELS)) begin
      pix = PIX_W'(RowPixMax);
    end else begin
      pix = PIX_W'(row_width);
    end
    chans     = (channel_count == 2'd0) ? 2'd1 : channel_count;
    pix_chans = {2'b00, pix} * {{PIX_W{1'b0}}, chans};
    row_len   = (state_r == prsd_pkg::S_BITS) ? CNT_W'(pix) : CNT_W'(pix_chans);
    cnt_inc   = {1'b0, cnt_r} + 1'b1;
    row_end   = cnt_inc >= {1'b0, row_len};
  end

  // Scaling helpers: value times full range by shift and subtract.
  assign wide     = max_value > prsd_pkg::BYTE_MAX;
  assign full     = wide ? prsd_pkg::FULL_WIDE : prsd_pkg::FULL_NARROW;
  assign scaled   = wide ? ({val_r, 16'd0} - {16'd0, val_r})
                         : ({8'd0, val_r, 8'd0} - {16'd0, val_r});
  assign trial    = {rem_r, quo_r[15]};
  assign trial_ge = trial >= {1'b0, max_value};

  // Sequencer of the back end.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    shift_nxt      = shift_r;
    bit_nxt        = bit_r;
    val_nxt        = val_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    pop            = 1'b0;
    case (state_r)
      prsd_pkg::S_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          if (pop_item.kind == prsd_pkg::KIND_BITMAP) begin
            shift_nxt = pop_item.data[7:0];
            bit_nxt   = 3'd0;
            state_nxt = prsd_pkg::S_BITS;
          end else if (max_value == 16'd0) begin
            quo_nxt   = full;
            state_nxt = prsd_pkg::S_EMIT;
          end else begin
            val_nxt   = (pop_item.data < max_value) ? pop_item.data : max_value;
            state_nxt = prsd_pkg::S_PREP;
          end
        end
      end
      prsd_pkg::S_PREP: begin
        rem_nxt   = scaled[31:16];
        quo_nxt   = scaled[15:0];
        step_nxt  = 4'd0;
        state_nxt = prsd_pkg::S_DIV;
      end
      prsd_pkg::S_DIV: begin
        // One restoring division step per cycle.
        rem_nxt  = trial_ge ? 16'(trial - {1'b0, max_value}) : trial[15:0];
        quo_nxt  = {quo_r[14:0], trial_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == prsd_pkg::STEP_LAST) begin
          state_nxt = prsd_pkg::S_EMIT;
        end
      end
      prsd_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = quo_r;
          out_last_nxt   = row_end;
          cnt_nxt        = row_end ? '0 : cnt_inc[CNT_W-1:0];
          state_nxt      = prsd_pkg::S_IDLE;
        end
      end
      prsd_pkg::S_BITS: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = shift_r[7] ? 16'd0 : prsd_pkg::BYTE_MAX;
          out_last_nxt   = row_end;
          cnt_nxt        = row_end ? '0 : cnt_inc[CNT_W-1:0];
          shift_nxt      = {shift_r[6:0], 1'b0};
          bit_nxt        = bit_r + 1'b1;
          if (row_end || bit_r == prsd_pkg::BIT_LAST) begin
            state_nxt = prsd_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = prsd_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prsd_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    shift_r      <= shift_nxt;
    bit_r        <= bit_nxt;
    val_r        <= val_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

### tb/pnm_raster_sample_decoder_core_tb.sv
// Testbench of pnm_raster_sample_decoder_core: directed and random raster bytes with a
// self-checking sample predictor and random idling on both channels.
// Depends on prsd_pkg and the RTL of the decoder core.
`timescale 1ns / 100ps

module pnm_raster_sample_decoder_core_tb;

  localparam int ROW_PIXELS_CAP = prsd_pkg::DEF_MAX_ROW_PIXELS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_SETTLE = 40;
  localparam int RANDOM_ITEMS = 180;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } sample_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [7:0]                      in_raw_byte = 8'd0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [15:0]                     out_sample_value;
  logic                            out_last_in_row;
  logic                            cfg_we = 1'b0;
  logic [prsd_pkg::CFG_IDX_W-1:0]  cfg_index = prsd_pkg::REG_RASTER_FORMAT;
  logic [prsd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register copies and decoder state held by the predictor.
  logic        reg_format;
  logic [1:0]  reg_chans;
  logic [15:0] reg_max;
  logic [12:0] reg_width;
  int unsigned row_count;
  logic [7:0]  high_byte;
  logic        high_pending;

  sample_t pending_samples[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      stall_left = 0;
  logic    tx_steady = 1'b0;
  logic    rx_steady = 1'b0;

  pnm_raster_sample_decoder_core #(
    .MAX_ROW_PIXELS(ROW_PIXELS_CAP)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_raw_byte     (in_raw_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_value(out_sample_value),
    .out_last_in_row (out_last_in_row),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  // The receiver stalls the result channel in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (!rx_steady) stall_left = pick_gap();
    end
  end

  // Advances the row position; true when this sample closes the row.
  function automatic logic close_row(input int unsigned row_len);
    if (row_count + 1 >= row_len) begin
      row_count = 0;
      return 1'b1;
    end
    row_count++;
    return 1'b0;
  endfunction

  // Works out the samples that one raster byte gives and queues them.
  task automatic decode_byte(input logic [7:0] b);
    int unsigned width, chans, raw, full, clamped;
    sample_t     s;
    int          k;
    logic        emit;
    width = (reg_width == 0) ? 1 : reg_width;
    if (width > ROW_PIXELS_CAP) width = ROW_PIXELS_CAP;
    if (reg_format == prsd_pkg::FMT_BITMAP) begin
      high_pending = 1'b0;
      high_byte = 8'd0;
      for (k = int'(prsd_pkg::BIT_LAST); k >= 0; k--) begin
        s.value = b[k] ? 16'd0 : prsd_pkg::FULL_NARROW;
        s.last = close_row(width);
        pending_samples.push_back(s);
        if (s.last) break;
      end
    end else begin
      chans = (reg_chans == 0) ? 1 : reg_chans;
      emit = 1'b1;
      raw = b;
      full = prsd_pkg::FULL_NARROW;
      if (reg_max > prsd_pkg::BYTE_MAX) begin
        if (!high_pending) begin
          high_byte = b;
          high_pending = 1'b1;
          emit = 1'b0;
        end else begin
          raw = {high_byte, b};
          full = prsd_pkg::FULL_WIDE;
        end
      end
      if (emit) begin
        high_pending = 1'b0;
        high_byte = 8'd0;
        if (reg_max == 0) begin
          s.value = full[15:0];
        end else begin
          clamped = (raw < reg_max) ? raw : reg_max;
          s.value = 16'((clamped * full) / reg_max);
        end
        s.last = close_row(width * chans);
        pending_samples.push_back(s);
      end
    end
  endtask

  // Compares every result beat with the oldest expected sample.
  always @(posedge clk) begin : check_beat
    sample_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected beat: value %0d last %0b", out_sample_value, out_last_in_row);
      end else begin
        exp_s = pending_samples.pop_front();
        if (out_sample_value !== exp_s.value || out_last_in_row !== exp_s.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                     exp_s.value, exp_s.last, out_sample_value, out_last_in_row);
        end
      end
    end
  end

  // Sends one raster byte; entered and left at a falling edge with valid low.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    in_raw_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every expected sample has arrived, then lets the block settle.
  task automatic wait_idle(input int settle);
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Writes one register and mirrors it in the predictor's copy.
  task automatic write_reg(input logic [prsd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      prsd_pkg::REG_RASTER_FORMAT: reg_format = data[0];
      prsd_pkg::REG_CHANNEL_COUNT: reg_chans = data[1:0];
      prsd_pkg::REG_MAX_VALUE:     reg_max = data;
      prsd_pkg::REG_ROW_WIDTH:     reg_width = data[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Sometimes sets bits above a register's width, which it must ignore.
  function automatic logic [15:0] with_junk(input logic [15:0] v, input logic [15:0] mask);
    logic [15:0] noise;
    noise = 16'($urandom);
    if ($urandom_range(0, 3) == 0) return v | (noise & ~mask);
    return v;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    else if (r < 20) return 8'hFF;
    else return 8'($urandom);
  endfunction

  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
  endtask

  // Bitmap rows, including padding dropped at a row end inside a byte.
  task automatic test_bitmap_rows();
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_RASTER_FORMAT, 16'(prsd_pkg::FMT_BITMAP));
    write_reg(prsd_pkg::REG_ROW_WIDTH, 16'd8);
    send_byte(8'hA5);
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_ROW_WIDTH, 16'd3);
    send_byte(8'hFF);
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_ROW_WIDTH, 16'd11);
    send_byte(8'h0F);
    send_byte(8'hF0);
  endtask

  // Single-byte samples: scaling, clamping, colour rows and a zero maximum.
  task automatic test_sample_scaling();
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_RASTER_FORMAT, 16'(prsd_pkg::FMT_SAMPLE));
    write_reg(prsd_pkg::REG_CHANNEL_COUNT, 16'd3);
    write_reg(prsd_pkg::REG_MAX_VALUE, 16'd100);
    write_reg(prsd_pkg::REG_ROW_WIDTH, 16'd1);
    send_byte(8'd0);
    send_byte(8'd100);
    send_byte(8'd101);
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_MAX_VALUE, 16'd0);
    send_byte(8'h12);
  endtask

  // Two-byte samples, and a held high byte dropped once the mode narrows.
  task automatic test_wide_samples();
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_CHANNEL_COUNT, 16'd1);
    write_reg(prsd_pkg::REG_MAX_VALUE, 16'd1000);
    write_reg(prsd_pkg::REG_ROW_WIDTH, 16'd2);
    send_byte(8'h01);
    send_byte(8'hF4);
    send_byte(8'hFF);
    send_byte(8'hFF);
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_MAX_VALUE, 16'hFFFF);
    send_byte(8'h12);
    send_byte(8'h34);
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_MAX_VALUE, 16'd256);
    send_byte(8'h01);
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_MAX_VALUE, 16'd255);
    send_byte(8'h40);
  endtask

  // A row narrowed below the current position ends on the next sample.
  task automatic test_row_shrink();
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_ROW_WIDTH, 16'd5);
    send_byte(8'd10);
    send_byte(8'd20);
    wait_idle(IDLE_SETTLE);
    write_reg(prsd_pkg::REG_ROW_WIDTH, 16'd1);
    send_byte(8'd30);
  endtask

  // Draws a new setting; some registers keep their value so state carries over.
  task automatic pick_config();
    logic [15:0] v;
    int          r;
    if ($urandom_range(0, 4) != 0) begin
      v = ($urandom_range(0, 4) < 2) ? 16'(prsd_pkg::FMT_BITMAP)
                                     : 16'(prsd_pkg::FMT_SAMPLE);
      write_reg(prsd_pkg::REG_RASTER_FORMAT, with_junk(v, 16'h0001));
    end
    if ($urandom_range(0, 4) != 0)
      write_reg(prsd_pkg::REG_CHANNEL_COUNT,
                with_junk(16'($urandom_range(0, 3)), 16'h0003));
    if ($urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 7))
        0: v = 16'd0;
        1: v = 16'd1;
        2: v = 16'd255;
        3: v = 16'd256;
        4: v = 16'hFFFF;
        5: v = 16'($urandom_range(2, 254));
        6: v = 16'($urandom_range(257, 65534));
        default: v = 16'($urandom_range(2, 20));
      endcase
      write_reg(prsd_pkg::REG_MAX_VALUE, v);
    end
    if ($urandom_range(0, 4) != 0) begin
      r = $urandom_range(0, 99);
      if (r < 70) v = 16'($urandom_range(0, 12));
      else if (r < 85) v = 16'($urandom_range(13, 40));
      else if (r < 90) v = 16'(ROW_PIXELS_CAP);
      else if (r < 95) v = 16'(ROW_PIXELS_CAP + 1);
      else v = 16'(prsd_pkg::ROW_WIDTH_REG_MAX);
      write_reg(prsd_pkg::REG_ROW_WIDTH, with_junk(v, 16'h1FFF));
    end
  endtask

  // Random phases of bytes, each under its own setting and idling pattern.
  task automatic test_random_phases();
    int sent, n, k, phase;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle(IDLE_SETTLE);
      pick_config();
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      n = $urandom_range(6, 28);
      for (k = 0; k < n; k++) begin
        // Once, the sender holds off until the block has emptied.
        if (phase == 1 && k == n / 2) wait_idle(0);
        send_byte(pick_byte());
      end
      sent += n;
      phase++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    reg_format = prsd_pkg::RST_RASTER_FORMAT;
    reg_chans = prsd_pkg::RST_CHANNEL_COUNT;
    reg_max = prsd_pkg::RST_MAX_VALUE;
    reg_width = prsd_pkg::RST_ROW_WIDTH;
    row_count = 0;
    high_byte = 8'd0;
    high_pending = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_bitmap_rows();
    test_sample_scaling();
    test_wide_samples();
    test_row_shrink();
    test_random_phases();

    wait_idle(IDLE_SETTLE);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/prsd_pkg.sv
hdl/prsd_front.sv
hdl/prsd_fifo.sv
hdl/prsd_back.sv
hdl/pnm_raster_sample_decoder_core.sv
tb/pnm_raster_sample_decoder_core_tb.sv
